// ----- sv/qvt_pkg.sv -----
// Package for the quaternion vertex transform: word types, config layout,
// shift amounts and pipeline control struct. No dependencies.
`default_nettype none

package qvt_pkg;

  localparam int STAGES = 5;

  // Fraction shifts of the fixed-point steps
  localparam int DOT_SHIFT = 14;  // Q1.14 * Q16.16 -> Q16.16
  localparam int ROT_SHIFT = 13;  // doubled term, then Q1.14 drop
  localparam int K_SHIFT   = 28;  // Q2.28 * Q16.16 -> Q16.16

  // Widths of the intermediates
  localparam int PROD_W  = 48;  // Q1.14 x Q16.16
  localparam int DOTS_W  = 50;  // sum of three products
  localparam int CRD_W   = 49;  // difference of two products
  localparam int DOT_W   = DOTS_W - DOT_SHIFT;  // 36
  localparam int CR_W    = CRD_W - DOT_SHIFT;   // 35
  localparam int SQ_W    = 32;
  localparam int K_W     = 33;
  localparam int DU_W    = DOT_W + 16;          // 52
  localparam int KP_W    = 64;
  localparam int SC_W    = CR_W + 16;           // 51
  localparam int R_W     = 41;
  localparam int T_W     = 42;

  typedef enum logic [2:0] {
    REG_ROT_W   = 3'd0,
    REG_ROT_X   = 3'd1,
    REG_ROT_Y   = 3'd2,
    REG_ROT_Z   = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5,
    REG_SHIFT_Z = 3'd6
  } cfg_reg_t;

  localparam logic signed [15:0] ROT_W_RESET = 16'sd16384;

  typedef struct packed {
    logic signed [15:0] rot_w;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               last_vertex;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               out_last;
  } out_word_t;

  // Front half to back half: stage-two results
  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic signed [K_W-1:0]   k;
    logic signed [CR_W-1:0]  cr_x;
    logic signed [CR_W-1:0]  cr_y;
    logic signed [CR_W-1:0]  cr_z;
    logic signed [31:0]      pos_x;
    logic signed [31:0]      pos_y;
    logic signed [31:0]      pos_z;
    logic                    last;
  } mid_t;

  // Load enables, bit i loads stage i+1
  typedef struct packed {
    logic [STAGES-1:0] en;
  } ctrl_t;

endpackage

`default_nettype wire

// ----- sv/qvt_cfg_regs.sv -----
// Configuration registers of the quaternion vertex transform.
// Depends on qvt_pkg for the register index codes and the cfg_t layout.
`default_nettype none

module qvt_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  output      logic          cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [31:0]   cfg_data,
  output      qvt_pkg::cfg_t cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rot_w   <= qvt_pkg::ROT_W_RESET;
      cfg.rot_x   <= '0;
      cfg.rot_y   <= '0;
      cfg.rot_z   <= '0;
      cfg.shift_x <= '0;
      cfg.shift_y <= '0;
      cfg.shift_z <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (qvt_pkg::cfg_reg_t'(cfg_index))
        qvt_pkg::REG_ROT_W:   cfg.rot_w   <= cfg_data[15:0];
        qvt_pkg::REG_ROT_X:   cfg.rot_x   <= cfg_data[15:0];
        qvt_pkg::REG_ROT_Y:   cfg.rot_y   <= cfg_data[15:0];
        qvt_pkg::REG_ROT_Z:   cfg.rot_z   <= cfg_data[15:0];
        qvt_pkg::REG_SHIFT_X: cfg.shift_x <= cfg_data;
        qvt_pkg::REG_SHIFT_Y: cfg.shift_y <= cfg_data;
        qvt_pkg::REG_SHIFT_Z: cfg.shift_z <= cfg_data;
        default: ;  // drop writes past the register list
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/qvt_ctrl.sv -----
// Valid bits and load enables of the five-stage transform pipeline.
// Depends on qvt_pkg for STAGES and ctrl_t.
`default_nettype none

module qvt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output      logic           in_stall,
  output      logic           out_valid,
  input  wire logic           out_stall,
  output      qvt_pkg::ctrl_t ctrl
);

  localparam int N = qvt_pkg::STAGES;

  logic [N-1:0] valid;
  logic [N-1:0] en;

  // A stage loads when it is empty or its word moves on
  always_comb begin
    en[N-1] = !valid[N-1] || !out_stall;
    for (int i = N - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < N; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign ctrl.en   = en;
  assign in_stall  = !en[0];
  assign out_valid = valid[N-1];

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&valid && out_stall))
    else $error("input stalled with a bubble in the pipeline");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> valid[0])
    else $error("accepted word did not enter stage one");

  a_last_stage_fills: assert property (@(posedge clk) disable iff (rst)
    valid[N-2] && en[N-1] |=> out_valid)
    else $error("word lost between last two stages");

  a_no_loss_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled word dropped from the last stage");

endmodule

`default_nettype wire

// ----- sv/qvt_front.sv -----
// Stages one and two: all products of the quaternion with the vertex, then
// the dot product, cross product and scale factor k. Depends on qvt_pkg.
`default_nettype none

module qvt_front (
  input  wire logic             clk,
  input  wire qvt_pkg::ctrl_t   ctrl,
  input  wire qvt_pkg::cfg_t    cfg,
  input  wire qvt_pkg::in_word_t in_word,
  output      qvt_pkg::mid_t    mid
);

  localparam int PW = qvt_pkg::PROD_W;

  logic signed [15:0] u [3];
  logic signed [31:0] p [3];

  // Stage one registers
  logic signed [PW-1:0]           pu  [3];  // u_i * p_i
  logic signed [PW-1:0]           cra [3];  // u_j * p_k
  logic signed [PW-1:0]           crb [3];  // u_k * p_j
  logic signed [qvt_pkg::SQ_W-1:0] sq [3];
  logic signed [qvt_pkg::SQ_W-1:0] ss;
  logic signed [31:0]             p1  [3];
  logic                           last1;

  // Stage two combinational
  logic signed [qvt_pkg::DOTS_W-1:0] dot_sum;
  logic signed [qvt_pkg::CRD_W-1:0]  cr_diff [3];
  logic signed [qvt_pkg::K_W-1:0]    sq_sum;

  assign u[0] = cfg.rot_x;
  assign u[1] = cfg.rot_y;
  assign u[2] = cfg.rot_z;
  assign p[0] = in_word.pos_x;
  assign p[1] = in_word.pos_y;
  assign p[2] = in_word.pos_z;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    always_ff @(posedge clk) begin
      if (ctrl.en[0]) begin
        pu[i]  <= PW'(u[i]) * PW'(p[i]);
        cra[i] <= PW'(u[J]) * PW'(p[K]);
        crb[i] <= PW'(u[K]) * PW'(p[J]);
        sq[i]  <= qvt_pkg::SQ_W'(u[i]) * qvt_pkg::SQ_W'(u[i]);
        p1[i]  <= p[i];
      end
    end

    assign cr_diff[i] = qvt_pkg::CRD_W'(cra[i]) - qvt_pkg::CRD_W'(crb[i]);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      ss    <= qvt_pkg::SQ_W'(cfg.rot_w) * qvt_pkg::SQ_W'(cfg.rot_w);
      last1 <= in_word.last_vertex;
    end
  end

  assign dot_sum = qvt_pkg::DOTS_W'(pu[0]) + qvt_pkg::DOTS_W'(pu[1])
                 + qvt_pkg::DOTS_W'(pu[2]);
  assign sq_sum  = qvt_pkg::K_W'(sq[0]) + qvt_pkg::K_W'(sq[1]) + qvt_pkg::K_W'(sq[2]);

  // Arithmetic shifts by taking the upper bits
  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      mid.dot   <= dot_sum[qvt_pkg::DOTS_W-1:qvt_pkg::DOT_SHIFT];
      mid.k     <= qvt_pkg::K_W'(ss) - sq_sum;
      mid.cr_x  <= cr_diff[0][qvt_pkg::CRD_W-1:qvt_pkg::DOT_SHIFT];
      mid.cr_y  <= cr_diff[1][qvt_pkg::CRD_W-1:qvt_pkg::DOT_SHIFT];
      mid.cr_z  <= cr_diff[2][qvt_pkg::CRD_W-1:qvt_pkg::DOT_SHIFT];
      mid.pos_x <= p1[0];
      mid.pos_y <= p1[1];
      mid.pos_z <= p1[2];
      mid.last  <= last1;
    end
  end

endmodule

`default_nettype wire

// ----- sv/qvt_back.sv -----
// Stages three to five: rotation terms, their sum, then translation and
// saturation into the output word. Depends on qvt_pkg.
`default_nettype none

module qvt_back (
  input  wire logic              clk,
  input  wire qvt_pkg::ctrl_t    ctrl,
  input  wire qvt_pkg::cfg_t     cfg,
  input  wire qvt_pkg::mid_t     mid,
  output      qvt_pkg::out_word_t out_word
);

  localparam int DUW = qvt_pkg::DU_W;
  localparam int KPW = qvt_pkg::KP_W;
  localparam int SCW = qvt_pkg::SC_W;
  localparam int RW  = qvt_pkg::R_W;
  localparam int TW  = qvt_pkg::T_W;
  localparam logic signed [TW-1:0] SAT_MAX = TW'(2147483647);
  localparam logic signed [TW-1:0] SAT_MIN = -TW'(64'sd2147483648);

  logic signed [15:0]          u   [3];
  logic signed [31:0]          p   [3];
  logic signed [qvt_pkg::CR_W-1:0] cr [3];
  logic signed [31:0]          t   [3];

  logic signed [DUW-1:0] du [3];
  logic signed [KPW-1:0] kp [3];
  logic signed [SCW-1:0] sc [3];
  logic                  last3;
  logic signed [RW-1:0]  r  [3];
  logic                  last4;
  logic signed [TW-1:0]  tot [3];
  logic signed [31:0]    sat [3];

  assign u[0]  = cfg.rot_x;
  assign u[1]  = cfg.rot_y;
  assign u[2]  = cfg.rot_z;
  assign t[0]  = cfg.shift_x;
  assign t[1]  = cfg.shift_y;
  assign t[2]  = cfg.shift_z;
  assign p[0]  = mid.pos_x;
  assign p[1]  = mid.pos_y;
  assign p[2]  = mid.pos_z;
  assign cr[0] = mid.cr_x;
  assign cr[1] = mid.cr_y;
  assign cr[2] = mid.cr_z;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    always_ff @(posedge clk) begin
      if (ctrl.en[2]) begin
        du[i] <= DUW'(mid.dot) * DUW'(u[i]);
        kp[i] <= KPW'(mid.k) * KPW'(p[i]);
        sc[i] <= SCW'(cfg.rot_w) * SCW'(cr[i]);
      end
    end

    // Doubling then dropping 14 bits is a drop of 13 bits
    always_ff @(posedge clk) begin
      if (ctrl.en[3]) begin
        r[i] <= RW'($signed(du[i][DUW-1:qvt_pkg::ROT_SHIFT]))
              + RW'($signed(kp[i][KPW-1:qvt_pkg::K_SHIFT]))
              + RW'($signed(sc[i][SCW-1:qvt_pkg::ROT_SHIFT]));
      end
    end

    assign tot[i] = TW'(r[i]) + TW'(t[i]);

    always_comb begin
      if (tot[i] > SAT_MAX) begin
        sat[i] = 32'sh7FFF_FFFF;
      end else if (tot[i] < SAT_MIN) begin
        sat[i] = 32'sh8000_0000;
      end else begin
        sat[i] = tot[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      last3 <= mid.last;
    end
    if (ctrl.en[3]) begin
      last4 <= last3;
    end
    if (ctrl.en[4]) begin
      out_word.out_x    <= sat[0];
      out_word.out_y    <= sat[1];
      out_word.out_z    <= sat[2];
      out_word.out_last <= last4;
    end
  end

endmodule

`default_nettype wire

// ----- sv/quaternion_vertex_transform_top.sv -----
// Top level of the quaternion vertex transform: rotates a Q16.16 vertex by a
// Q1.14 quaternion, adds a translation and saturates. Uses qvt_pkg and the
// qvt_cfg_regs, qvt_ctrl, qvt_front and qvt_back modules.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------
//   in      | in_valid / in_stall | in_word  (pos_x, pos_y, pos_z, last)
//   out     | out_valid/out_stall | out_word (out_x, out_y, out_z, last)
//   cfg     | cfg_valid/cfg_ready | cfg_index (3 b), cfg_data (32 b)
//
// One vertex per cycle while out_stall is low; there are five register
// stages (products, dot/cross/k, rotation products, sum, translate+saturate).
// A stalled output holds its word; bubbles ahead of it still fill, and the
// input stalls only once all five stages are full.
// Reset (rst, synchronous) empties the pipeline and loads the identity
// quaternion with zero translation. cfg_ready is always high.
`default_nettype none

module quaternion_vertex_transform_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire qvt_pkg::in_word_t  in_word,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      qvt_pkg::out_word_t out_word,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  qvt_pkg::cfg_t  cfg;
  qvt_pkg::ctrl_t ctrl;
  qvt_pkg::mid_t  mid;

  qvt_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  qvt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl)
  );

  qvt_front u_front (
    .clk     (clk),
    .ctrl    (ctrl),
    .cfg     (cfg),
    .in_word (in_word),
    .mid     (mid)
  );

  qvt_back u_back (
    .clk      (clk),
    .ctrl     (ctrl),
    .cfg      (cfg),
    .mid      (mid),
    .out_word (out_word)
  );

endmodule

`default_nettype wire
